/* hw/rtl/nps_pkg.sv */
// Shared types, widths and constants of the priority scheduler.
`default_nettype none

package nps_pkg;

    localparam int MAX_JOBS_DEF = 64;

    localparam int ARR_W      = 16;
    localparam int BURST_W    = 16;
    localparam int PRIO_W     = 8;
    localparam int TIME_W     = 23;
    localparam int SUM_W      = 29;
    localparam int JOB_IDX_W  = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_USE_ARRIVAL = 3'd0;

    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } job_entry_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE,
        ST_OUT_READ,
        ST_OUT_CALC,
        ST_OUT_HOLD
    } nps_state_t;

    typedef struct packed {
        logic load;
        logic batch_start;
        logic scan;
        logic decide;
        logic out_read;
        logic out_calc;
        logic out_take;
    } nps_cmd_t;

    typedef struct packed {
        logic batch_end;
        logic scan_done;
        logic last_pick;
        logic out_last;
    } nps_status_t;

endpackage

`default_nettype wire

/* hw/rtl/nps_if.sv */
// Valid/ready channel interfaces for job items and result items.
`default_nettype none

interface nps_in_if;
    logic                        valid;
    logic                        ready;
    logic [nps_pkg::ARR_W-1:0]   arrival_time;
    logic [nps_pkg::BURST_W-1:0] burst_time;
    logic [nps_pkg::PRIO_W-1:0]  job_priority;
    logic                        last_job;

    modport source (output valid, output arrival_time, output burst_time,
                    output job_priority, output last_job, input ready);
    modport sink   (input valid, input arrival_time, input burst_time,
                    input job_priority, input last_job, output ready);
endinterface

interface nps_out_if;
    logic                          valid;
    logic                          ready;
    logic [nps_pkg::JOB_IDX_W-1:0] job_index;
    logic [nps_pkg::TIME_W-1:0]    start_time;
    logic [nps_pkg::TIME_W-1:0]    completion_time;
    logic [nps_pkg::TIME_W-1:0]    turnaround_time;
    logic [nps_pkg::TIME_W-1:0]    waiting_time;
    logic [nps_pkg::TIME_W-1:0]    response_time;
    logic [nps_pkg::SUM_W-1:0]     sum_turnaround;
    logic [nps_pkg::SUM_W-1:0]     sum_waiting;
    logic [nps_pkg::SUM_W-1:0]     sum_response;
    logic                          last_result;

    modport source (output valid, output job_index, output start_time,
                    output completion_time, output turnaround_time,
                    output waiting_time, output response_time,
                    output sum_turnaround, output sum_waiting, output sum_response,
                    output last_result, input ready);
    modport sink   (input valid, input job_index, input start_time,
                    input completion_time, input turnaround_time,
                    input waiting_time, input response_time,
                    input sum_turnaround, input sum_waiting, input sum_response,
                    input last_result, output ready);
endinterface

`default_nettype wire

/* hw/rtl/nps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/nps_regs.sv */
// APB configuration register block of the priority scheduler.
`default_nettype none

module nps_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [nps_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [nps_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [nps_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output logic                                  use_arrival
);

    logic use_arrival_reg;
    logic use_arrival_next;
    logic hit;

    assign hit    = (paddr == nps_pkg::ADDR_USE_ARRIVAL);
    assign pready = 1'b1;

    always_comb
    begin
        use_arrival_next = use_arrival_reg;
        if (psel && penable && pwrite && hit)
        begin
            use_arrival_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_arrival_reg <= 1'b1;
        end
        else
        begin
            use_arrival_reg <= use_arrival_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata = {{(nps_pkg::APB_DATA_W-1){1'b0}}, use_arrival_reg};
        end
    end

    assign use_arrival = use_arrival_reg;

endmodule

`default_nettype wire

/* hw/rtl/nps_ctrl.sv */
// Sequencer: load, repeated scan/decide passes, then result output.
`default_nettype none

module nps_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 out_ready,
    input  wire nps_pkg::nps_status_t status,
    output logic                      in_ready,
    output logic                      out_valid,
    output nps_pkg::nps_cmd_t         cmd
);

    nps_pkg::nps_state_t state_reg;
    nps_pkg::nps_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nps_pkg::ST_LOAD:
            begin
                if (in_valid && status.batch_end)
                begin
                    state_next = nps_pkg::ST_SCAN;
                end
            end
            nps_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = nps_pkg::ST_DECIDE;
                end
            end
            nps_pkg::ST_DECIDE:
            begin
                state_next = status.last_pick ? nps_pkg::ST_OUT_READ : nps_pkg::ST_SCAN;
            end
            nps_pkg::ST_OUT_READ:
            begin
                state_next = nps_pkg::ST_OUT_CALC;
            end
            nps_pkg::ST_OUT_CALC:
            begin
                state_next = nps_pkg::ST_OUT_HOLD;
            end
            nps_pkg::ST_OUT_HOLD:
            begin
                if (out_ready)
                begin
                    state_next = status.out_last ? nps_pkg::ST_LOAD : nps_pkg::ST_OUT_READ;
                end
            end
            default:
            begin
                state_next = nps_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nps_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            nps_pkg::ST_LOAD:
            begin
                in_ready        = 1'b1;
                cmd.load        = in_valid;
                cmd.batch_start = in_valid && status.batch_end;
            end
            nps_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            nps_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
            end
            nps_pkg::ST_OUT_READ:
            begin
                cmd.out_read = 1'b1;
            end
            nps_pkg::ST_OUT_CALC:
            begin
                cmd.out_calc = 1'b1;
            end
            nps_pkg::ST_OUT_HOLD:
            begin
                out_valid    = 1'b1;
                cmd.out_take = out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/nps_dp.sv */
// Datapath: job store, selection scan, schedule clock, result arithmetic.
`default_nettype none

module nps_dp #(
    parameter int MAX_JOBS = nps_pkg::MAX_JOBS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire nps_pkg::nps_cmd_t                 cmd,
    output nps_pkg::nps_status_t                   status,
    input  wire logic                              use_arrival,
    input  wire logic [nps_pkg::ARR_W-1:0]         arrival_time,
    input  wire logic [nps_pkg::BURST_W-1:0]       burst_time,
    input  wire logic [nps_pkg::PRIO_W-1:0]        job_priority,
    input  wire logic                              last_job,
    output logic      [nps_pkg::JOB_IDX_W-1:0]     job_index,
    output logic      [nps_pkg::TIME_W-1:0]        start_time,
    output logic      [nps_pkg::TIME_W-1:0]        completion_time,
    output logic      [nps_pkg::TIME_W-1:0]        turnaround_time,
    output logic      [nps_pkg::TIME_W-1:0]        waiting_time,
    output logic      [nps_pkg::TIME_W-1:0]        response_time,
    output logic      [nps_pkg::SUM_W-1:0]         sum_turnaround,
    output logic      [nps_pkg::SUM_W-1:0]         sum_waiting,
    output logic      [nps_pkg::SUM_W-1:0]         sum_response,
    output logic                                   last_result
);

    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int TW    = nps_pkg::TIME_W;
    localparam int SW    = nps_pkg::SUM_W;

    // control registers
    logic [CNT_W-1:0]          job_count_reg, job_count_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic [CNT_W-1:0]          left_reg, left_next;
    logic [CNT_W-1:0]          scan_idx_reg, scan_idx_next;
    logic                      eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0]          eval_idx_reg, eval_idx_next;
    logic [MAX_JOBS-1:0]       done_reg, done_next;
    logic [TW-1:0]             clock_reg, clock_next;
    logic                      pick_valid_reg, pick_valid_next;
    logic                      any_reg, any_next;
    logic [CNT_W-1:0]          out_idx_reg, out_idx_next;

    // payload registers
    logic [IDX_W-1:0]             pick_idx_reg, pick_idx_next;
    logic [nps_pkg::PRIO_W-1:0]   pick_prio_reg, pick_prio_next;
    logic [nps_pkg::ARR_W-1:0]    pick_arr_reg, pick_arr_next;
    logic [nps_pkg::BURST_W-1:0]  pick_burst_reg, pick_burst_next;
    logic [nps_pkg::ARR_W-1:0]    earliest_reg, earliest_next;
    logic [SW-1:0]                acc_t_reg, acc_t_next;
    logic [SW-1:0]                acc_w_reg, acc_w_next;
    logic [SW-1:0]                acc_r_reg, acc_r_next;

    logic [nps_pkg::JOB_IDX_W-1:0] job_index_reg;
    logic [TW-1:0]                 start_reg, compl_reg, turn_reg, wait_reg, resp_reg;
    logic [SW-1:0]                 sum_t_reg, sum_w_reg, sum_r_reg;
    logic                          last_reg;

    // memories
    nps_pkg::job_entry_t job_wdata;
    logic [$bits(nps_pkg::job_entry_t)-1:0] job_rbits;
    nps_pkg::job_entry_t job_rdata;
    logic [IDX_W-1:0]    rd_addr;
    logic [TW-1:0]       start_rdata;

    logic [CNT_W-1:0]    count_plus;
    logic                issue;
    logic                cand_better;
    logic                out_is_last;
    logic [TW-1:0]       calc_c, calc_t, calc_w, calc_r;

    assign job_wdata.arrival = use_arrival ? arrival_time : '0;
    assign job_wdata.burst   = burst_time;
    assign job_wdata.prio    = job_priority;
    assign job_rdata         = nps_pkg::job_entry_t'(job_rbits);

    assign rd_addr = cmd.out_read ? out_idx_reg[IDX_W-1:0] : scan_idx_reg[IDX_W-1:0];

    nps_ram #(
        .WIDTH ($bits(nps_pkg::job_entry_t)),
        .DEPTH (MAX_JOBS)
    ) u_job_ram (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (job_count_reg[IDX_W-1:0]),
        .wdata (job_wdata),
        .raddr (rd_addr),
        .rdata (job_rbits)
    );

    nps_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_JOBS)
    ) u_start_ram (
        .clk   (clk),
        .we    (cmd.decide && pick_valid_reg),
        .waddr (pick_idx_reg),
        .wdata (clock_reg),
        .raddr (rd_addr),
        .rdata (start_rdata)
    );

    assign count_plus = job_count_reg + CNT_W'(1);
    assign issue      = (scan_idx_reg < n_reg);

    // higher priority wins; equal priority goes to the strictly earlier arrival
    assign cand_better = !pick_valid_reg
                      || (job_rdata.prio > pick_prio_reg)
                      || ((job_rdata.prio == pick_prio_reg)
                          && (job_rdata.arrival < pick_arr_reg));

    assign calc_c      = start_rdata + TW'(job_rdata.burst);
    assign calc_t      = calc_c - TW'(job_rdata.arrival);
    assign calc_w      = calc_t - TW'(job_rdata.burst);
    assign calc_r      = start_rdata - TW'(job_rdata.arrival);
    assign out_is_last = ((out_idx_reg + CNT_W'(1)) == n_reg);

    assign status.batch_end = last_job || (count_plus == CNT_W'(MAX_JOBS));
    assign status.scan_done = !issue && !eval_valid_reg;
    assign status.last_pick = pick_valid_reg && (left_reg == CNT_W'(1));
    assign status.out_last  = last_reg;

    always_comb
    begin
        job_count_next  = job_count_reg;
        n_next          = n_reg;
        left_next       = left_reg;
        scan_idx_next   = scan_idx_reg;
        eval_valid_next = eval_valid_reg;
        eval_idx_next   = eval_idx_reg;
        done_next       = done_reg;
        clock_next      = clock_reg;
        pick_valid_next = pick_valid_reg;
        any_next        = any_reg;
        out_idx_next    = out_idx_reg;
        pick_idx_next   = pick_idx_reg;
        pick_prio_next  = pick_prio_reg;
        pick_arr_next   = pick_arr_reg;
        pick_burst_next = pick_burst_reg;
        earliest_next   = earliest_reg;
        acc_t_next      = acc_t_reg;
        acc_w_next      = acc_w_reg;
        acc_r_next      = acc_r_reg;

        if (cmd.load)
        begin
            job_count_next = count_plus;
        end

        if (cmd.batch_start)
        begin
            n_next          = count_plus;
            left_next       = count_plus;
            scan_idx_next   = '0;
            eval_valid_next = 1'b0;
            done_next       = '0;
            clock_next      = '0;
            pick_valid_next = 1'b0;
            any_next        = 1'b0;
        end

        if (cmd.scan)
        begin
            // issue one read per cycle, evaluate it in the cycle after
            eval_valid_next = issue;
            eval_idx_next   = scan_idx_reg[IDX_W-1:0];
            if (issue)
            begin
                scan_idx_next = scan_idx_reg + CNT_W'(1);
            end
            if (eval_valid_reg && !done_reg[eval_idx_reg])
            begin
                if (!any_reg || (job_rdata.arrival < earliest_reg))
                begin
                    earliest_next = job_rdata.arrival;
                    any_next      = 1'b1;
                end
                if ((TW'(job_rdata.arrival) <= clock_reg) && cand_better)
                begin
                    pick_valid_next = 1'b1;
                    pick_idx_next   = eval_idx_reg;
                    pick_prio_next  = job_rdata.prio;
                    pick_arr_next   = job_rdata.arrival;
                    pick_burst_next = job_rdata.burst;
                end
            end
        end

        if (cmd.decide)
        begin
            if (pick_valid_reg)
            begin
                clock_next              = clock_reg + TW'(pick_burst_reg);
                done_next[pick_idx_reg] = 1'b1;
                left_next               = left_reg - CNT_W'(1);
            end
            else
            begin
                // nothing ready: jump to the next arrival
                clock_next = TW'(earliest_reg);
            end
            scan_idx_next   = '0;
            pick_valid_next = 1'b0;
            any_next        = 1'b0;
            out_idx_next    = '0;
            acc_t_next      = '0;
            acc_w_next      = '0;
            acc_r_next      = '0;
        end

        if (cmd.out_calc)
        begin
            out_idx_next = out_idx_reg + CNT_W'(1);
            acc_t_next   = acc_t_reg + SW'(calc_t);
            acc_w_next   = acc_w_reg + SW'(calc_w);
            acc_r_next   = acc_r_reg + SW'(calc_r);
        end

        if (cmd.out_take && last_reg)
        begin
            job_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_count_reg  <= '0;
            n_reg          <= '0;
            left_reg       <= '0;
            scan_idx_reg   <= '0;
            eval_valid_reg <= 1'b0;
            eval_idx_reg   <= '0;
            done_reg       <= '0;
            clock_reg      <= '0;
            pick_valid_reg <= 1'b0;
            any_reg        <= 1'b0;
            out_idx_reg    <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            job_count_reg  <= job_count_next;
            n_reg          <= n_next;
            left_reg       <= left_next;
            scan_idx_reg   <= scan_idx_next;
            eval_valid_reg <= eval_valid_next;
            eval_idx_reg   <= eval_idx_next;
            done_reg       <= done_next;
            clock_reg      <= clock_next;
            pick_valid_reg <= pick_valid_next;
            any_reg        <= any_next;
            out_idx_reg    <= out_idx_next;
            if (cmd.out_calc)
            begin
                last_reg <= out_is_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pick_idx_reg   <= pick_idx_next;
        pick_prio_reg  <= pick_prio_next;
        pick_arr_reg   <= pick_arr_next;
        pick_burst_reg <= pick_burst_next;
        earliest_reg   <= earliest_next;
        acc_t_reg      <= acc_t_next;
        acc_w_reg      <= acc_w_next;
        acc_r_reg      <= acc_r_next;
        if (cmd.out_calc)
        begin
            job_index_reg <= nps_pkg::JOB_IDX_W'(out_idx_reg[IDX_W-1:0]);
            start_reg     <= start_rdata;
            compl_reg     <= calc_c;
            turn_reg      <= calc_t;
            wait_reg      <= calc_w;
            resp_reg      <= calc_r;
            sum_t_reg     <= out_is_last ? acc_t_next : '0;
            sum_w_reg     <= out_is_last ? acc_w_next : '0;
            sum_r_reg     <= out_is_last ? acc_r_next : '0;
        end
    end

    assign job_index       = job_index_reg;
    assign start_time      = start_reg;
    assign completion_time = compl_reg;
    assign turnaround_time = turn_reg;
    assign waiting_time    = wait_reg;
    assign response_time   = resp_reg;
    assign sum_turnaround  = sum_t_reg;
    assign sum_waiting     = sum_w_reg;
    assign sum_response    = sum_r_reg;
    assign last_result     = last_reg;

endmodule

`default_nettype wire

/* hw/rtl/nonpreemptive_priority_scheduler.sv */
// Load: one job item per cycle; the job that is marked last or fills the store ends the batch.
// Schedule: each decision is a pass of N RAM reads, each evaluated, then a drain and a decide step;
//   a batch takes N decisions plus one extra pass per idle-time jump.
// Output: each result item takes a RAM read, an arithmetic step and a hold until the sink is ready.
// One batch at a time; no new job is taken until the batch's last result is delivered.
// Reset (rst_n, async, active low) clears all control state and sets use_arrival_times to 1.
`default_nettype none

module nonpreemptive_priority_scheduler #(
    parameter int MAX_JOBS = nps_pkg::MAX_JOBS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    nps_in_if.sink                                job_in,
    nps_out_if.source                             result_out,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [nps_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [nps_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [nps_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready
);

    logic                 use_arrival;
    nps_pkg::nps_cmd_t    cmd;
    nps_pkg::nps_status_t status;

    nps_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .use_arrival (use_arrival)
    );

    nps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (job_in.valid),
        .out_ready (result_out.ready),
        .status    (status),
        .in_ready  (job_in.ready),
        .out_valid (result_out.valid),
        .cmd       (cmd)
    );

    nps_dp #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .use_arrival     (use_arrival),
        .arrival_time    (job_in.arrival_time),
        .burst_time      (job_in.burst_time),
        .job_priority    (job_in.job_priority),
        .last_job        (job_in.last_job),
        .job_index       (result_out.job_index),
        .start_time      (result_out.start_time),
        .completion_time (result_out.completion_time),
        .turnaround_time (result_out.turnaround_time),
        .waiting_time    (result_out.waiting_time),
        .response_time   (result_out.response_time),
        .sum_turnaround  (result_out.sum_turnaround),
        .sum_waiting     (result_out.sum_waiting),
        .sum_response    (result_out.sum_response),
        .last_result     (result_out.last_result)
    );

endmodule

`default_nettype wire

/* hw/rtl/nps_checker.sv */
// Port-level checks of the priority scheduler, bound to the top level.
`default_nettype none

module nps_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic                          in_last_job,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic                          out_last_result,
    input  wire logic [nps_pkg::SUM_W-1:0]     out_sum_turnaround,
    input  wire logic [nps_pkg::SUM_W-1:0]     out_sum_waiting
);

    // loading and result delivery never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is offered");

    // a last job closes the batch: no further job is taken next cycle
    a_batch_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last_job) |=> !in_ready)
        else $error("job accepted right after the last job of a batch");

    // after the final result of a batch, nothing more is offered
    a_batch_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last_result) |=> !out_valid)
        else $error("result offered after the last result of a batch");

    // turnaround and waiting totals are zero except on the last result
    a_sums_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last_result) |->
            (out_sum_turnaround == '0) && (out_sum_waiting == '0))
        else $error("nonzero total on a result that is not the last");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped without handshake");

endmodule

bind nonpreemptive_priority_scheduler nps_checker u_nps_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (job_in.valid),
    .in_ready           (job_in.ready),
    .in_last_job        (job_in.last_job),
    .out_valid          (result_out.valid),
    .out_ready          (result_out.ready),
    .out_last_result    (result_out.last_result),
    .out_sum_turnaround (result_out.sum_turnaround),
    .out_sum_waiting    (result_out.sum_waiting)
);

`default_nettype wire

/* sim/nonpreemptive_priority_scheduler_tb.sv */
// Self-checking testbench for the priority scheduler: job batches in, per-job timing results out.

module nonpreemptive_priority_scheduler_tb;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 600000;
    localparam int JOB_SLOTS   = nps_pkg::MAX_JOBS_DEF;
    localparam int ARR_W       = nps_pkg::ARR_W;
    localparam int BURST_W     = nps_pkg::BURST_W;
    localparam int PRIO_W      = nps_pkg::PRIO_W;
    localparam int TIME_W      = nps_pkg::TIME_W;
    localparam int SUM_W       = nps_pkg::SUM_W;
    localparam int JOB_IDX_W   = nps_pkg::JOB_IDX_W;
    localparam int APB_ADDR_W  = nps_pkg::APB_ADDR_W;
    localparam int APB_DATA_W  = nps_pkg::APB_DATA_W;

    typedef struct packed {
        logic [JOB_IDX_W-1:0] job_index;
        logic [TIME_W-1:0]    start_time;
        logic [TIME_W-1:0]    completion_time;
        logic [TIME_W-1:0]    turnaround_time;
        logic [TIME_W-1:0]    waiting_time;
        logic [TIME_W-1:0]    response_time;
        logic [SUM_W-1:0]     sum_turnaround;
        logic [SUM_W-1:0]     sum_waiting;
        logic [SUM_W-1:0]     sum_response;
        logic                 last_result;
    } job_timing_t;

    logic clk = 1'b0;
    logic rst_n;

    always #CLK_HALF clk = ~clk;

    nps_in_if  job_if ();
    nps_out_if res_if ();

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  sink_ready = 1'b0;

    assign res_if.ready = sink_ready;

    nonpreemptive_priority_scheduler dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_in     (job_if),
        .result_out (res_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Mirror of the job stores and mode register
    logic [ARR_W-1:0]   arr_mem   [JOB_SLOTS];
    logic [BURST_W-1:0] burst_mem [JOB_SLOTS];
    logic [PRIO_W-1:0]  prio_mem  [JOB_SLOTS];
    int                 loaded_jobs = 0;
    bit                 arrival_on  = 1'b1;

    job_timing_t timing_queue[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          quiet       = 1'b0;
    int          stall_left  = 0;

    function automatic int draw_gap(input int long_max);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, long_max);
    endfunction

    // Run the whole batch to completion, then queue one timing record per job
    function automatic void schedule_batch(input int n);
        bit                done     [JOB_SLOTS];
        logic [TIME_W-1:0] start_at [JOB_SLOTS];
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] earliest;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic [TIME_W-1:0] s;
        logic [TIME_W-1:0] c;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] w;
        logic [TIME_W-1:0] rs;
        logic [SUM_W-1:0]  sum_t;
        logic [SUM_W-1:0]  sum_w;
        logic [SUM_W-1:0]  sum_r;
        job_timing_t       rec;
        int                left;
        int                pick;
        bit                any;
        foreach (done[i])
            done[i] = 1'b0;
        now   = '0;
        left  = n;
        sum_t = '0;
        sum_w = '0;
        sum_r = '0;
        while (left > 0)
        begin
            pick     = -1;
            any      = 1'b0;
            earliest = '0;
            for (int i = 0; i < n; i++)
            begin
                if (!done[i])
                begin
                    a = TIME_W'(arr_mem[i]);
                    if (!any || a < earliest)
                    begin
                        earliest = a;
                        any      = 1'b1;
                    end
                    if (a <= now)
                    begin
                        if (pick < 0 || prio_mem[i] > prio_mem[pick] ||
                            (prio_mem[i] == prio_mem[pick] && arr_mem[i] < arr_mem[pick]))
                            pick = i;
                    end
                end
            end
            if (pick < 0)
                now = earliest;   // nothing ready: jump to next arrival
            else
            begin
                b              = TIME_W'(burst_mem[pick]);
                start_at[pick] = now;
                now            = now + b;
                done[pick]     = 1'b1;
                left--;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            a     = TIME_W'(arr_mem[i]);
            b     = TIME_W'(burst_mem[i]);
            s     = start_at[i];
            c     = s + b;
            t     = c - a;
            w     = t - b;
            rs    = s - a;
            sum_t = sum_t + SUM_W'(t);
            sum_w = sum_w + SUM_W'(w);
            sum_r = sum_r + SUM_W'(rs);
            rec.job_index       = i[JOB_IDX_W-1:0];
            rec.start_time      = s;
            rec.completion_time = c;
            rec.turnaround_time = t;
            rec.waiting_time    = w;
            rec.response_time   = rs;
            rec.last_result     = (i == n - 1);
            rec.sum_turnaround  = rec.last_result ? sum_t : '0;
            rec.sum_waiting     = rec.last_result ? sum_w : '0;
            rec.sum_response    = rec.last_result ? sum_r : '0;
            timing_queue.push_back(rec);
        end
    endfunction

    function automatic void record_job(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst,
                                       input logic [PRIO_W-1:0] prio, input logic last);
        arr_mem[loaded_jobs]   = arrival_on ? arr : '0;
        burst_mem[loaded_jobs] = burst;
        prio_mem[loaded_jobs]  = prio;
        loaded_jobs++;
        // a full store closes the batch even without the last mark
        if (last || loaded_jobs == JOB_SLOTS)
        begin
            schedule_batch(loaded_jobs);
            loaded_jobs = 0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_result();
        job_timing_t want;
        if (timing_queue.size() == 0)
        begin
            $error("result item for job %0d with no result expected", res_if.job_index);
            error_count++;
            return;
        end
        want = timing_queue.pop_front();
        check_field("job_index", 32'(want.job_index), 32'(res_if.job_index));
        check_field("start_time", 32'(want.start_time), 32'(res_if.start_time));
        check_field("completion_time", 32'(want.completion_time),
                    32'(res_if.completion_time));
        check_field("turnaround_time", 32'(want.turnaround_time),
                    32'(res_if.turnaround_time));
        check_field("waiting_time", 32'(want.waiting_time), 32'(res_if.waiting_time));
        check_field("response_time", 32'(want.response_time), 32'(res_if.response_time));
        check_field("sum_turnaround", 32'(want.sum_turnaround), 32'(res_if.sum_turnaround));
        check_field("sum_waiting", 32'(want.sum_waiting), 32'(res_if.sum_waiting));
        check_field("sum_response", 32'(want.sum_response), 32'(res_if.sum_response));
        check_field("last_result", 32'(want.last_result), 32'(res_if.last_result));
    endfunction

    // Result side: check every accepted item, then pick the next ready with random stalls
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            check_result();
        if (!rst_n)
            sink_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            sink_ready <= 1'b0;
        end
        else
        begin
            stall_left = draw_gap(40);
            if (stall_left > 0)
            begin
                stall_left--;
                sink_ready <= 1'b0;
            end
            else
                sink_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("nonpreemptive_priority_scheduler regression: fail");
            $finish;
        end
    end

    // Entered and left just after a rising edge; valid stays high for a back-to-back item
    task automatic send_job(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst,
                            input logic [PRIO_W-1:0] prio, input logic last);
        int gap;
        gap = draw_gap(30);
        if (gap > 0)
        begin
            job_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        job_if.valid        <= 1'b1;
        job_if.arrival_time <= arr;
        job_if.burst_time   <= burst;
        job_if.job_priority <= prio;
        job_if.last_job     <= last;
        do
            @(posedge clk);
        while (!job_if.ready);
        record_job(arr, burst, prio, last);
    endtask

    // Drop valid, drain every expected result, then let the block settle
    task automatic wait_idle();
        job_if.valid <= 1'b0;
        while (timing_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_arrival_mode(input bit on);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= nps_pkg::ADDR_USE_ARRIVAL;
        pwdata  <= APB_DATA_W'(on);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        arrival_on = on;
        // read back in the next transfer
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== APB_DATA_W'(on))
        begin
            $error("use_arrival_times: expected %0d, got %0d", on, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_batch(input int n, input bit marked);
        int                 arr_style;
        int                 burst_style;
        int                 prio_style;
        logic [ARR_W-1:0]   a;
        logic [ARR_W-1:0]   shared_arr;
        logic [BURST_W-1:0] b;
        logic [PRIO_W-1:0]  p;
        arr_style   = $urandom_range(0, 2);
        burst_style = $urandom_range(0, 2);
        prio_style  = $urandom_range(0, 2);
        shared_arr  = ARR_W'($urandom);
        for (int i = 0; i < n; i++)
        begin
            case (arr_style)
                0:       a = ARR_W'($urandom);
                1:       a = ARR_W'($urandom_range(0, 40));
                default: a = shared_arr;
            endcase
            case (burst_style)
                0:       b = BURST_W'($urandom);
                1:       b = BURST_W'($urandom_range(0, 20));
                default: b = ($urandom_range(0, 3) == 0) ? '0 : BURST_W'($urandom_range(1, 5));
            endcase
            case (prio_style)
                0:       p = PRIO_W'($urandom);
                1:       p = PRIO_W'($urandom_range(0, 3));
                default: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            endcase
            send_job(a, b, p, marked && (i == n - 1));
        end
    endtask

    task automatic test_extremes();
        send_job(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        send_job(16'h0000, 16'h0000, 8'h00, 1'b1);
        send_job(16'h0000, 16'hFFFF, 8'h00, 1'b0);
        send_job(16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
        send_job(16'h0000, 16'hFFFF, 8'hFF, 1'b1);
    endtask

    task automatic test_tie_breaks();
        send_job(16'd5, 16'd3, 8'd7, 1'b0);
        send_job(16'd2, 16'd4, 8'd7, 1'b0);   // same priority, earlier arrival
        send_job(16'd2, 16'd1, 8'd7, 1'b0);   // same priority and arrival, higher index
        send_job(16'd3, 16'd2, 8'd9, 1'b0);   // higher priority arrives mid-run, no preemption
        send_job(16'd40, 16'd5, 8'd1, 1'b0);  // arrives after the rest: idle jump
        send_job(16'd0, 16'd0, 8'd0, 1'b1);   // only one ready at zero, zero burst
        send_job(16'd1000, 16'd8, 8'd4, 1'b0);
        send_job(16'd1000, 16'd2, 8'd4, 1'b0);
        send_job(16'd1000, 16'd6, 8'd4, 1'b1);
    endtask

    task automatic test_arrival_mode();
        wait_idle();
        set_arrival_mode(1'b0);
        send_job(16'd900, 16'd12, 8'd3, 1'b0);
        send_job(16'hFFFF, 16'd7, 8'd200, 1'b0);
        send_job(16'd17, 16'd30, 8'd3, 1'b0);
        send_job(16'd4, 16'd1, 8'd255, 1'b1);
        wait_idle();
        set_arrival_mode(1'b1);
    endtask

    task automatic test_full_store();
        quiet = 1'b1;
        send_random_batch(JOB_SLOTS, 1'b0);
        quiet = 1'b0;
    endtask

    task automatic test_random_phases();
        int sent;
        int n;
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            if (phase == 1)
                set_arrival_mode(1'b0);
            else if (phase == 3)
                set_arrival_mode(1'($urandom_range(0, 1)));
            else
                set_arrival_mode(1'b1);
            quiet = (phase == 2);
            sent  = 0;
            while (sent < 34)
            begin
                n = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 8) : $urandom_range(9, 24);
                send_random_batch(n, 1'b1);
                sent += n;
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        job_if.valid        <= 1'b0;
        job_if.arrival_time <= '0;
        job_if.burst_time   <= '0;
        job_if.job_priority <= '0;
        job_if.last_job     <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_tie_breaks();
        test_arrival_mode();
        test_full_store();
        test_random_phases();

        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0 && timing_queue.size() == 0)
            $display("nonpreemptive_priority_scheduler regression: pass");
        else
            $display("nonpreemptive_priority_scheduler regression: fail");
        $finish;
    end

endmodule
